### hdl/ctm_pkg.sv
package ctm_pkg;

  localparam int TexHeightDefault   = 256;
  localparam int ScreenRowsDefault  = 1024;
  localparam int MapSize            = 256;
  localparam int BlendSize          = 65536;

  typedef enum logic [2:0] {
    REQ_TEXEL  = 3'd0,
    REQ_LIGHT  = 3'd1,
    REQ_SECTOR = 3'd2,
    REQ_TRANS  = 3'd3,
    REQ_BLEND  = 3'd4,
    REQ_START  = 3'd5,
    REQ_PIXEL  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    MODE_PLAIN     = 3'd0,
    MODE_MASKED    = 3'd1,
    MODE_TRANS     = 3'd2,
    MODE_TRANS_MSK = 3'd3,
    MODE_HOLEY     = 3'd4,
    MODE_HOLEY_MSK = 3'd5,
    MODE_BLEND_A   = 3'd6,
    MODE_BLEND_B   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_CENTER = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_SPRITE = 3'd3,
    CFG_PHASE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_WRAP,
    BK_PX_MOD,
    BK_PX_ADDR,
    BK_PX_TEX,
    BK_PX_XLAT,
    BK_PX_SECT,
    BK_PX_LIGHT,
    BK_PX_PAL,
    BK_PX_OUT
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        table_index;
    logic [7:0]         table_value;
    logic [9:0]         column_x;
    logic [9:0]         row_low;
    logic [9:0]         row_high;
    logic signed [31:0] texture_mid;
    logic signed [31:0] step;
    logic [7:0]         dest_pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_row;
    logic [7:0] color;
    logic       write_enable;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [9:0] center_row;
    logic [8:0] texture_height;
    logic       is_sprite;
    logic       hole_phase;
  } cfg_t;

endpackage

### hdl/column_texture_mapper.sv
// Vertical-column texture mapper. Load items fill the texture, light,
// sector colour, translation and blend memories; a start item sets the
// column and a pixel item yields one result while a column is active;
// a negative start is wrapped by adding one texture span at a time. A
// pixel reduces the integer part by the height, folds a negative part
// up, and runs the chain of registered memory reads. A result waiting
// at the output holds the back end until it is taken.
module column_texture_mapper import ctm_pkg::*; #(
  parameter int TexHeight  = TexHeightDefault,
  parameter int ScreenRows = ScreenRowsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t     cfg;
  logic     q_valid;
  logic     q_take;
  in_item_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_PLAIN;
      cfg.center_row     <= 10'd100;
      cfg.texture_height <= 9'd128;
      cfg.is_sprite      <= 1'b0;
      cfg.hole_phase     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:   cfg.mode           <= cfg_data[2:0];
        CFG_CENTER: cfg.center_row     <= cfg_data[9:0];
        CFG_HEIGHT: cfg.texture_height <= cfg_data[8:0];
        CFG_SPRITE: cfg.is_sprite      <= cfg_data[0];
        CFG_PHASE:  cfg.hole_phase     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ctm_front #(.Depth(4)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .q_valid, .q_take, .q_data);

  ctm_back #(.TexHeight(TexHeight), .ScreenRows(ScreenRows)) u_back (
    .clk, .rst, .cfg, .q_valid, .q_take, .q_data, .out_valid, .out_stall, .out_data);

endmodule

### hdl/ctm_ram.sv
module ctm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ctm_front.sv
module ctm_front import ctm_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output in_item_t q_data
);

  localparam int AW = $clog2(Depth);

  in_item_t        fifo [Depth];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;
  logic            keep;

  assign in_stall = (count == (AW+1)'(Depth));
  assign keep     = (in_data.req_type != REQ_NONE);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_take;
  assign q_data   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_data;
    end
  end

endmodule

### hdl/ctm_back.sv
module ctm_back import ctm_pkg::*; #(
  parameter int TexHeight  = TexHeightDefault,
  parameter int ScreenRows = ScreenRowsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_take,
  input  in_item_t  q_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int TAW = $clog2(TexHeight);
  localparam int HW  = $clog2(TexHeight + 1);

  bk_state_t state, state_next;

  in_item_t        item;
  logic [31:0]     coord;
  logic [31:0]     step_latch;
  logic [9:0]      current_row;
  logic [9:0]      end_row;
  logic            dither_parity;
  logic            column_active;
  logic [31:0]     product;
  logic [31:0]     start_c;
  logic [TAW-1:0]  tidx;
  logic [15:0]     hi_pos;
  logic [7:0]      src;
  logic [7:0]      xval;
  logic            we_pix;
  logic [HW-1:0]   eff_h;
  logic [32:0]     span;
  logic            wrap_more;

  logic [16:0]     mod_acc;
  logic [16:0]     mod_acc_next;
  logic            mod_neg;
  logic [1:0]      mod_cnt;
  logic [24:0]     mod_div;
  logic [3:0]      mod_sh;

  logic            tex_we,  light_we, sect_we, trans_we, blend_we;
  logic [TAW-1:0]  tex_raddr;
  logic [7:0]      tex_rd, light_rd, sect_rd, trans_rd, blend_rd;
  logic [7:0]      light_ra, sect_ra, trans_ra;
  logic [15:0]     blend_ra;

  logic [9:0]      high_lim;
  logic            empty_col;
  logic            clamp;
  logic            load_item;

  always_comb begin
    if (cfg.texture_height == '0) begin
      eff_h = HW'(1);
    end else if ({23'd0, cfg.texture_height} > 32'(TexHeight)) begin
      eff_h = HW'(TexHeight);
    end else begin
      eff_h = HW'(cfg.texture_height);
    end
  end

  assign span = {1'b0, 16'(eff_h), 16'd0};

  // negative start still below zero after one more span
  assign wrap_more = ({1'b0, coord} + span < 33'h1_0000_0000);

  assign high_lim  = ({22'd0, item.row_high} > 32'(ScreenRows - 1)) ?
                     10'(ScreenRows - 1) : item.row_high;
  assign empty_col = (high_lim <= item.row_low);
  assign clamp     = (cfg.mode == MODE_HOLEY) ||
                     (((cfg.mode == MODE_PLAIN) || (cfg.mode == MODE_TRANS)) && cfg.is_sprite);

  assign load_item = q_valid && (state == BK_IDLE) && !out_valid &&
                     (q_data.req_type != REQ_START) && (q_data.req_type != REQ_PIXEL);

  assign tex_we   = load_item && (q_data.req_type == REQ_TEXEL) &&
                    ({16'd0, q_data.table_index} < 32'(TexHeight));
  assign light_we = load_item && (q_data.req_type == REQ_LIGHT) && (q_data.table_index < 16'(MapSize));
  assign sect_we  = load_item && (q_data.req_type == REQ_SECTOR) && (q_data.table_index < 16'(MapSize));
  assign trans_we = load_item && (q_data.req_type == REQ_TRANS) && (q_data.table_index < 16'(MapSize));
  assign blend_we = load_item && (q_data.req_type == REQ_BLEND);

  assign tex_raddr = tidx;
  assign trans_ra  = src;
  assign sect_ra   = xval;
  assign light_ra  = sect_rd;
  assign blend_ra  = (cfg.mode == MODE_BLEND_A) ? {item.dest_pixel, src} : {src, item.dest_pixel};

  ctm_ram #(.Width(8), .Depth(TexHeight)) u_tex (
    .clk, .we(tex_we), .waddr(q_data.table_index[TAW-1:0]), .wdata(q_data.table_value),
    .raddr(tex_raddr), .rdata(tex_rd));
  ctm_ram #(.Width(8), .Depth(MapSize)) u_light (
    .clk, .we(light_we), .waddr(q_data.table_index[7:0]), .wdata(q_data.table_value),
    .raddr(light_ra), .rdata(light_rd));
  ctm_ram #(.Width(8), .Depth(MapSize)) u_sect (
    .clk, .we(sect_we), .waddr(q_data.table_index[7:0]), .wdata(q_data.table_value),
    .raddr(sect_ra), .rdata(sect_rd));
  ctm_ram #(.Width(8), .Depth(MapSize)) u_trans (
    .clk, .we(trans_we), .waddr(q_data.table_index[7:0]), .wdata(q_data.table_value),
    .raddr(trans_ra), .rdata(trans_rd));
  ctm_ram #(.Width(8), .Depth(BlendSize)) u_blend (
    .clk, .we(blend_we), .waddr(q_data.table_index), .wdata(q_data.table_value),
    .raddr(blend_ra), .rdata(blend_rd));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && !out_valid) begin
          if (q_data.req_type == REQ_START) begin
            state_next = BK_MUL;
          end else if (q_data.req_type == REQ_PIXEL && column_active) begin
            state_next = BK_PX_MOD;
          end
        end
      end
      BK_MUL:      state_next = BK_SUM;
      BK_SUM:      state_next = (empty_col || !start_c[31] || clamp) ? BK_IDLE : BK_WRAP;
      BK_WRAP:     state_next = wrap_more ? BK_WRAP : BK_IDLE;
      BK_PX_MOD:   state_next = (mod_cnt == 2'd3) ? BK_PX_ADDR : BK_PX_MOD;
      BK_PX_ADDR:  state_next = BK_PX_TEX;
      BK_PX_TEX:   state_next = BK_PX_XLAT;
      BK_PX_XLAT:  state_next = BK_PX_SECT;
      BK_PX_SECT:  state_next = BK_PX_LIGHT;
      BK_PX_LIGHT: state_next = BK_PX_PAL;
      BK_PX_PAL:   state_next = BK_PX_OUT;
      BK_PX_OUT:   state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_take = 1'b0;
    unique case (state)
      BK_IDLE: q_take = q_valid && !out_valid &&
                        !((q_data.req_type == REQ_START) ||
                          (q_data.req_type == REQ_PIXEL && column_active));
      BK_SUM:  q_take = empty_col || !start_c[31] || clamp;
      BK_WRAP: q_take = !wrap_more;
      BK_PX_OUT: q_take = 1'b1;
      default: q_take = 1'b0;
    endcase
  end

  assign start_c = item.texture_mid + product;
  assign hi_pos  = coord[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      coord         <= '0;
      current_row   <= '0;
      end_row       <= '0;
      dither_parity <= 1'b0;
      column_active <= 1'b0;
      step_latch    <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_SUM: begin
          if (empty_col) begin
            column_active     <= 1'b0;
            out_valid         <= 1'b1;
            out_data.out_row      <= item.row_low;
            out_data.color        <= '0;
            out_data.write_enable <= 1'b0;
            out_data.last_pixel   <= 1'b1;
          end else begin
            coord         <= (start_c[31] && clamp) ? '0 : start_c;
            step_latch    <= item.step;
            current_row   <= item.row_low;
            end_row       <= high_lim;
            dither_parity <= cfg.hole_phase ^ item.column_x[0] ^ item.row_low[0];
            column_active <= 1'b1;
          end
        end
        BK_WRAP: begin
          coord <= coord + span[31:0];
        end
        BK_PX_OUT: begin
          out_valid             <= 1'b1;
          out_data.out_row      <= current_row;
          out_data.color        <= we_pix ? light_rd : '0;
          out_data.write_enable <= we_pix;
          out_data.last_pixel   <= (current_row == end_row);
          if (current_row == end_row) begin
            column_active <= 1'b0;
          end else begin
            current_row   <= current_row + 10'd1;
            coord         <= coord + step_latch;
            dither_parity <= ~dither_parity;
          end
        end
        default: ;
      endcase
    end
  end

  // texel index: magnitude of the integer part reduced by the height,
  // four restoring steps a cycle, negative parts folded up afterwards
  always_comb begin
    mod_acc_next = mod_acc;
    mod_div      = '0;
    mod_sh       = '0;
    for (int s = 0; s < 4; s++) begin
      mod_sh  = 4'(15 - 4 * int'(mod_cnt) - s);
      mod_div = 25'(eff_h) << mod_sh;
      if ({8'd0, mod_acc_next} >= mod_div) begin
        mod_acc_next = 17'({8'd0, mod_acc_next} - mod_div);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        item    <= q_data;
        mod_acc <= hi_pos[15] ? 17'h1_0000 - {1'b0, hi_pos} : {1'b0, hi_pos};
        mod_neg <= hi_pos[15];
        mod_cnt <= '0;
      end
      BK_MUL: product <= 32'(({22'd0, item.row_low} - {22'd0, cfg.center_row}) * item.step);
      BK_PX_MOD: begin
        mod_acc <= mod_acc_next;
        mod_cnt <= mod_cnt + 2'd1;
      end
      BK_PX_ADDR: tidx <= TAW'((mod_neg && mod_acc != '0) ? 17'(eff_h) - mod_acc : mod_acc);
      BK_PX_TEX: ;
      BK_PX_XLAT: begin
        src <= tex_rd;
      end
      BK_PX_SECT: ;
      default: ;
    endcase
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_PLAIN:     begin we_pix = 1'b1;                    xval = src;      end
      MODE_MASKED:    begin we_pix = src != 0;                xval = src;      end
      MODE_TRANS:     begin we_pix = 1'b1;                    xval = trans_rd; end
      MODE_TRANS_MSK: begin we_pix = src != 0;                xval = trans_rd; end
      MODE_HOLEY:     begin we_pix = dither_parity;           xval = src;      end
      MODE_HOLEY_MSK: begin we_pix = src != 0 && dither_parity; xval = src;    end
      default:        begin we_pix = src != 0;                xval = blend_rd; end
    endcase
  end

endmodule
